[design/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants and types for the pipelined prime sieve core.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int DEFAULT_NUM_STAGES  = 64;
   localparam int DEFAULT_VALUE_WIDTH = 16;

   // smallest candidate that can be prime
   localparam int MIN_CANDIDATE = 2;

   // status from the shared remainder unit back to the sequencer
   typedef struct packed {
      logic done;      // one-cycle pulse, remainder is final
      logic rem_zero;  // remainder is zero, valid with done
   } pps_div_status_type;

endpackage

[design/pps_divider.sv]
// ----------------------------------------------------------------------------
// pps_divider
// Restoring remainder unit, one quotient bit per cycle. Start loads dividend
// and divisor; done pulses once the last bit is through, with the zero flag.
// ----------------------------------------------------------------------------
module pps_divider
   import pps_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [VALUE_WIDTH-1:0]   dividend,
   input  logic [VALUE_WIDTH-1:0]   divisor,
   output pps_div_status_type       status
);

   localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   assign trial = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(VALUE_WIDTH - 1);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so it fits the width
         rem_in = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
         dvd_in = {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

[design/pps_table.sv]
// ----------------------------------------------------------------------------
// pps_table
// Divisor store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_table
   import pps_pkg::*;
#(
   parameter int NUM_STAGES  = DEFAULT_NUM_STAGES,
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
   localparam int IDX_W      = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  logic [VALUE_WIDTH-1:0] wr_data,
   input  logic                   rd_en,
   input  logic [IDX_W-1:0]       rd_addr,
   output logic [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] mem [NUM_STAGES];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pipelined_prime_sieve_core.sv]
// ----------------------------------------------------------------------------
// pipelined_prime_sieve_core
// Prime sieve: each candidate is tested against every stored divisor by one
// shared remainder unit; survivors are emitted and kept while room remains.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------------
//   req     | in  | tdata: candidate
//   rsp     | out | tdata: prime; tuser: stored
//
// For each stored divisor in turn an item passes a table read, a unit load, the
// divide at one bit per cycle and a result check, stopping at the first exact
// divisor, then an emit step. Candidates below two are dropped as they are accepted.
// The remainder unit and the single table read port take one divisor at a time.
// Reset is synchronous and clears the fill count; no clearing pass is needed.
// req_tready is low while an item is in work; a stalled rsp holds the emit step.
// ----------------------------------------------------------------------------
module pipelined_prime_sieve_core
   import pps_pkg::*;
#(
   parameter int NUM_STAGES  = DEFAULT_NUM_STAGES,
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
   localparam int DATA_W     = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [VALUE_WIDTH-1:0] candidate
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [VALUE_WIDTH-1:0] prime
   output logic              rsp_tuser    // [0] stored
);

   localparam int IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
   localparam int CNT_W = $clog2(NUM_STAGES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       filled_ff, filled_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] prime_ff, prime_in;
   logic                   stored_ff, stored_in;

   logic [VALUE_WIDTH-1:0] candidate;
   logic [CNT_W-1:0]       idx_next;
   logic                   table_full;
   logic                   slot_free;
   logic                   emit_go;
   logic                   wr_en;
   logic                   rd_en;
   logic                   div_start;
   logic [VALUE_WIDTH-1:0] rd_data;
   pps_div_status_type     div_status;

   assign candidate  = req_tdata[VALUE_WIDTH-1:0];
   assign idx_next   = CNT_W'(idx_ff) + CNT_W'(1);
   assign table_full = (filled_ff == CNT_W'(NUM_STAGES));
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign emit_go    = (state_ff == ST_EMIT) && slot_free;
   assign wr_en      = emit_go && !table_full;
   assign rd_en      = (state_ff == ST_READ);
   assign div_start  = (state_ff == ST_START);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      filled_in    = filled_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      prime_in     = prime_ff;
      stored_in    = stored_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               value_in = candidate;
               idx_in   = '0;
               if (candidate < VALUE_WIDTH'(MIN_CANDIDATE)) begin
                  state_in = ST_IDLE;
               end else if (filled_ff == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (div_status.rem_zero) begin
                  state_in = ST_IDLE;          // exact divisor found, drop
               end else if (idx_next == filled_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  idx_in   = idx_next[IDX_W-1:0];
                  state_in = ST_READ;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               prime_in     = value_ff;
               stored_in    = !table_full;
               if (!table_full) begin
                  filled_in = filled_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      prime_ff  <= prime_in;
      stored_ff <= stored_in;
   end

   pps_table #(
      .NUM_STAGES  (NUM_STAGES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (filled_ff[IDX_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   pps_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (value_ff),
      .divisor  (rd_data),
      .status   (div_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(prime_ff);
   assign rsp_tuser  = stored_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(NUM_STAGES))
      else $error("fill count beyond table depth");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> filled_ff == $past(filled_ff) + CNT_W'(1))
      else $error("fill count did not advance on table write");

   a_div_index: assert property (@(posedge clock) disable iff (reset)
      div_start |-> CNT_W'(idx_ff) < filled_ff)
      else $error("remainder unit started on an unfilled entry");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("remainder result outside the divide step");
`endif

endmodule
